[hdl/stpf_pkg.sv]
// ----------------------------------------------------------------------------
// Slip thermostat pair force package
// Word types of the pair and result channels, register indexes and constants.
// ----------------------------------------------------------------------------
package stpf_pkg;

	// Bits of the pair weight w, which lies in [0, 1.0] as unsigned Q16.
	localparam int unsigned W_BITS = 17;

	localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] Y_LIMIT = 64'(MAX48 / 48'd24);

	typedef enum logic [2:0] {
		CFG_TEMPERATURE   = 3'd0,
		CFG_FRICTION      = 3'd1,
		CFG_CUTOFF_RADIUS = 3'd2,
		CFG_TIME_SCALE    = 3'd3,
		CFG_REF_VEL_X     = 3'd4,
		CFG_REF_VEL_Y     = 3'd5,
		CFG_REF_VEL_Z     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [31:0] pair_distance;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic        [15:0] rand_x;
		logic        [15:0] rand_y;
		logic        [15:0] rand_z;
		logic signed [31:0] acc_force_x;
		logic signed [31:0] acc_force_y;
		logic signed [31:0] acc_force_z;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] new_force_x;
		logic signed [31:0] new_force_y;
		logic signed [31:0] new_force_z;
	} result_t;

endpackage

[hdl/slip_thermostat_pair_force.sv]
// ----------------------------------------------------------------------------
// Slip thermostat pair force
// Dissipative plus random pair force in Q16.16, added to an accumulated force.
// ----------------------------------------------------------------------------
// Each pair word passes the entry, divider, root, multiply, sum and output stages.
// Throughput: one pair word per cycle while no recompute or result stall holds it;
// the per-pair weight divider and square root are unrolled one quotient or root bit
// per stage, 17 stages each. Reset and every register write start a recompute of the
// register-derived factors in a shared bit-serial divider and root unit, during which
// pair words are stalled. Reset clears all valid bits.
module slip_thermostat_pair_force (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            pair_valid,
	output logic            pair_stall,
	input  stpf_pkg::pair_t pair_data,
	output logic            result_valid,
	input  logic            result_stall,
	output stpf_pkg::result_t result_data
);
	import stpf_pkg::*;

	localparam int unsigned DIV_N   = W_BITS;
	localparam int unsigned SQ_N    = W_BITS;
	localparam int unsigned IDX_SQ0 = 1 + DIV_N;
	localparam int unsigned IDX_M1  = IDX_SQ0 + SQ_N;
	localparam int unsigned NSTG    = IDX_M1 + 5;

	typedef struct packed {
		logic        dneg;
		logic [48:0] dm;
		logic        rneg;
		logic [15:0] rm;
		logic signed [31:0] acc;
	} comp_t;

	typedef struct packed {
		logic        in_range;
		logic        nbit;
		logic [31:0] rem;
		logic [16:0] q;
		comp_t [2:0] comp;
	} dstg_t;

	typedef struct packed {
		logic [33:0] rad;
		logic [18:0] rem;
		logic [16:0] root;
		logic [16:0] w;
		comp_t [2:0] comp;
	} sstg_t;

	typedef struct packed {
		logic [40:0] a_lo;
		logic [40:0] a_hi;
		logic [47:0] cp;
		comp_t [2:0] comp;
	} m1_t;

	typedef struct packed {
		logic [47:0] a;
		logic [31:0] c;
		comp_t [2:0] comp;
	} m2_t;

	typedef struct packed {
		logic [48:0] pll;
		logic [47:0] plh;
		logic [48:0] phl;
		logic [47:0] phh;
		logic [47:0] nmf;
		logic        dneg;
		logic        rneg;
		logic signed [31:0] acc;
	} m3c_t;

	typedef struct packed {
		logic [40:0] diss;
		logic signed [32:0] noise;
		logic        dneg;
		logic signed [31:0] acc;
	} m4c_t;

	typedef enum logic [2:0] {
		SQ_START, SQ_PDIV, SQ_PROD, SQ_XDIV, SQ_ROOT, SQ_SVEL, SQ_IDLE
	} seq_state_t;

	function automatic dstg_t div_step(input dstg_t d, input logic [31:0] rc,
			input logic first);
		dstg_t       r;
		logic [32:0] sh;
		logic [32:0] dv;
		logic        ge;
		r     = d;
		sh    = {d.rem, first & d.nbit};
		dv    = {1'b0, rc};
		ge    = (sh >= dv);
		r.rem = ge ? 32'(sh - dv) : sh[31:0];
		r.q   = {d.q[W_BITS-2:0], ge};
		return r;
	endfunction

	function automatic sstg_t sq_step(input sstg_t s);
		sstg_t       r;
		logic [20:0] sh;
		logic [20:0] tr;
		logic        ge;
		r      = s;
		sh     = {s.rem, s.rad[33:32]};
		tr     = {2'b00, s.root, 2'b01};
		ge     = (sh >= tr);
		r.rem  = ge ? 19'(sh - tr) : sh[18:0];
		r.root = {s.root[W_BITS-2:0], ge};
		r.rad  = {s.rad[31:0], 2'b00};
		return r;
	endfunction

	// Registers and derived factors
	logic [31:0]        temperature_q, friction_q, cutoff_radius_q, time_scale_q;
	logic signed [31:0] ref_vel_q [3];
	seq_state_t         state_q;
	logic [5:0]         cnt_q;
	logic [31:0]        rem_q;
	logic [63:0]        dvd_q;
	logic [33:0]        srem_q;
	logic [31:0]        root_q;
	logic [47:0]        pdiss_q;
	logic [31:0]        prand_q;
	logic signed [48:0] sv_q [3];

	logic        busy;
	logic [32:0] dsh;
	logic        dge;
	logic [31:0] rem_n;
	logic [63:0] dvd_n;
	logic [35:0] ssh;
	logic [35:0] str;
	logic        sge;
	logic [33:0] srem_n;
	logic [31:0] root_n;
	logic [63:0] y24;
	logic [47:0] y48;
	logic signed [31:0] vr;
	logic [31:0] vr_mag;
	logic [63:0] sv_prod;

	assign busy      = (state_q != SQ_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		dsh    = {rem_q, dvd_q[63]};
		dge    = (dsh >= {1'b0, time_scale_q});
		rem_n  = dge ? 32'(dsh - {1'b0, time_scale_q}) : dsh[31:0];
		dvd_n  = {dvd_q[62:0], dge};
		ssh    = {srem_q, dvd_q[63:62]};
		str    = {2'b00, root_q, 2'b01};
		sge    = (ssh >= str);
		srem_n = sge ? 34'(ssh - str) : ssh[33:0];
		root_n = {root_q[30:0], sge};
		y24    = (dvd_n << 4) + (dvd_n << 3);
		y48    = (dvd_n > Y_LIMIT) ? MAX48 : y24[47:0];
		vr     = ref_vel_q[cnt_q[1:0]];
		vr_mag = vr[31] ? (~vr + 32'd1) : vr;
		sv_prod = 64'(vr_mag) * 64'(time_scale_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temperature_q   <= 32'h0001_0000;
			friction_q      <= 32'h0001_0000;
			cutoff_radius_q <= 32'h0001_0000;
			time_scale_q    <= 32'h0001_0000;
			ref_vel_q[0]    <= '0;
			ref_vel_q[1]    <= '0;
			ref_vel_q[2]    <= '0;
			state_q         <= SQ_START;
			cnt_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				state_q <= SQ_START;
				case (cfg_index)
					CFG_TEMPERATURE:   temperature_q   <= cfg_data;
					CFG_FRICTION:      friction_q      <= cfg_data;
					CFG_CUTOFF_RADIUS: cutoff_radius_q <= cfg_data;
					CFG_TIME_SCALE:    time_scale_q    <= cfg_data;
					CFG_REF_VEL_X:     ref_vel_q[0]    <= cfg_data;
					CFG_REF_VEL_Y:     ref_vel_q[1]    <= cfg_data;
					CFG_REF_VEL_Z:     ref_vel_q[2]    <= cfg_data;
					default: ;
				endcase
			end else begin
				case (state_q)
					SQ_START: begin
						cnt_q <= '0;
						if (time_scale_q == '0) begin
							// The factors saturate; only the noise root and the slip velocities are left to take.
							pdiss_q <= MAX48;
							dvd_q   <= {MAX48, 16'h0000};
							srem_q  <= '0;
							root_q  <= '0;
							state_q <= SQ_ROOT;
						end else begin
							dvd_q   <= {16'h0000, friction_q, 16'h0000};
							rem_q   <= '0;
							state_q <= SQ_PDIV;
						end
					end
					SQ_PDIV: begin
						rem_q <= rem_n;
						dvd_q <= dvd_n;
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'd63) begin
							pdiss_q <= dvd_n[47:0];
							state_q <= SQ_PROD;
						end
					end
					SQ_PROD: begin
						dvd_q   <= 64'(temperature_q) * 64'(friction_q);
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= SQ_XDIV;
					end
					SQ_XDIV: begin
						rem_q <= rem_n;
						if (cnt_q == 6'd63) begin
							dvd_q   <= {y48, 16'h0000};
							srem_q  <= '0;
							root_q  <= '0;
							cnt_q   <= '0;
							state_q <= SQ_ROOT;
						end else begin
							dvd_q <= dvd_n;
							cnt_q <= cnt_q + 6'd1;
						end
					end
					SQ_ROOT: begin
						srem_q <= srem_n;
						root_q <= root_n;
						dvd_q  <= {dvd_q[61:0], 2'b00};
						if (cnt_q == 6'd31) begin
							prand_q <= root_n;
							cnt_q   <= '0;
							state_q <= SQ_SVEL;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
					SQ_SVEL: begin
						sv_q[cnt_q[1:0]] <= vr[31] ? -$signed({1'b0, sv_prod[63:16]})
							: $signed({1'b0, sv_prod[63:16]});
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'd2) begin
							state_q <= SQ_IDLE;
						end
					end
					SQ_IDLE: begin
						cnt_q <= '0;
					end
					default: begin
						state_q <= SQ_START;
					end
				endcase
			end
		end
	end

	// Pipeline control: a stage moves when it is empty or its successor moves.
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;
	logic            accept;

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || !result_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pair_stall = busy || !en[0];
	assign accept     = pair_valid && !pair_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= accept;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Entry stage: cutoff test, divider setup, velocity difference, noise sign.
	dstg_t ent_d;
	logic signed [31:0] vel [3];
	logic [15:0]        rnd [3];
	logic signed [31:0] acc [3];
	logic [31:0]        rc_diff;
	logic signed [49:0] diff [3];

	always_comb begin
		vel[0] = pair_data.vel_x;
		vel[1] = pair_data.vel_y;
		vel[2] = pair_data.vel_z;
		rnd[0] = pair_data.rand_x;
		rnd[1] = pair_data.rand_y;
		rnd[2] = pair_data.rand_z;
		acc[0] = pair_data.acc_force_x;
		acc[1] = pair_data.acc_force_y;
		acc[2] = pair_data.acc_force_z;
		rc_diff        = cutoff_radius_q - pair_data.pair_distance;
		ent_d.in_range = (pair_data.pair_distance < cutoff_radius_q);
		// The weight is below 2^17, so the top quotient bits are known zero.
		ent_d.rem      = {1'b0, rc_diff[31:1]};
		ent_d.nbit     = rc_diff[0];
		ent_d.q        = '0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = 50'(vel[i]) - 50'(sv_q[i]);
			ent_d.comp[i].dneg = diff[i][49];
			ent_d.comp[i].dm   = diff[i][49] ? 49'(-diff[i]) : diff[i][48:0];
			ent_d.comp[i].rneg = !rnd[i][15];
			ent_d.comp[i].rm   = rnd[i][15] ? {1'b0, rnd[i][14:0]}
				: 16'(17'h0_8000 - {1'b0, rnd[i]});
			ent_d.comp[i].acc  = acc[i];
		end
	end

	dstg_t ent_s1;
	dstg_t div_s2 [DIV_N];
	sstg_t sqr_s3 [SQ_N];
	sstg_t sq_first;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ent_s1 <= ent_d;
		end
	end

	for (genvar g = 0; g < DIV_N; g++) begin : g_div
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[1]) begin
					div_s2[0] <= div_step(ent_s1, cutoff_radius_q, 1'b1);
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en[1 + g]) begin
					div_s2[g] <= div_step(div_s2[g-1], cutoff_radius_q, 1'b0);
				end
			end
		end
	end

	always_comb begin
		sq_first.w    = div_s2[DIV_N-1].in_range ? div_s2[DIV_N-1].q : '0;
		sq_first.rad  = {1'b0, sq_first.w, 16'h0000};
		sq_first.rem  = '0;
		sq_first.root = '0;
		sq_first.comp = div_s2[DIV_N-1].comp;
	end

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqr
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[IDX_SQ0]) begin
					sqr_s3[0] <= sq_step(sq_first);
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en[IDX_SQ0 + g]) begin
					sqr_s3[g] <= sq_step(sqr_s3[g-1]);
				end
			end
		end
	end

	// Multiply and sum stages
	m1_t        mul_s4;
	m2_t        mul_s5;
	m3c_t [2:0] mul_s6;
	m4c_t [2:0] sum_s7;
	result_t    out_s8;
	sstg_t      sq_last;
	logic [64:0] a_sum;
	logic [96:0] prod [3];
	logic [47:0] nm [3];
	logic signed [43:0] fsum [3];
	logic signed [31:0] fsat [3];

	assign sq_last = sqr_s3[SQ_N-1];
	assign a_sum   = {mul_s4.a_hi, 24'h00_0000} + 65'(mul_s4.a_lo);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = 97'(mul_s6[i].pll) + (97'(mul_s6[i].plh) << 25)
				+ (97'(mul_s6[i].phl) << 24) + (97'(mul_s6[i].phh) << 49);
			nm[i]   = mul_s6[i].nmf;
			fsum[i] = 44'(sum_s7[i].acc) + 44'(sum_s7[i].noise)
				+ (sum_s7[i].dneg ? $signed(44'(sum_s7[i].diss))
				: -$signed(44'(sum_s7[i].diss)));
			if (fsum[i] > 44'sd2147483647) begin
				fsat[i] = 32'sh7FFF_FFFF;
			end else if (fsum[i] < -44'sd2147483648) begin
				fsat[i] = 32'sh8000_0000;
			end else begin
				fsat[i] = fsum[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[IDX_M1]) begin
			mul_s4.a_lo <= 41'(pdiss_q[23:0] * sq_last.w);
			mul_s4.a_hi <= 41'(pdiss_q[47:24] * sq_last.w);
			mul_s4.cp   <= 48'(prand_q * sq_last.root);
			mul_s4.comp <= sq_last.comp;
		end
		if (en[IDX_M1 + 1]) begin
			mul_s5.a    <= a_sum[63:16];
			mul_s5.c    <= mul_s4.cp[47:16];
			mul_s5.comp <= mul_s4.comp;
		end
		if (en[IDX_M1 + 2]) begin
			for (int i = 0; i < 3; i++) begin
				mul_s6[i].pll  <= 49'(mul_s5.a[23:0] * mul_s5.comp[i].dm[24:0]);
				mul_s6[i].plh  <= 48'(mul_s5.a[23:0] * mul_s5.comp[i].dm[48:25]);
				mul_s6[i].phl  <= 49'(mul_s5.a[47:24] * mul_s5.comp[i].dm[24:0]);
				mul_s6[i].phh  <= 48'(mul_s5.a[47:24] * mul_s5.comp[i].dm[48:25]);
				mul_s6[i].nmf  <= 48'(mul_s5.c * mul_s5.comp[i].rm);
				mul_s6[i].dneg <= mul_s5.comp[i].dneg;
				mul_s6[i].rneg <= mul_s5.comp[i].rneg;
				mul_s6[i].acc  <= mul_s5.comp[i].acc;
			end
		end
		if (en[IDX_M1 + 3]) begin
			for (int i = 0; i < 3; i++) begin
				// A product past 56 bits is capped; the output saturates either way.
				sum_s7[i].diss  <= (prod[i][96:56] != '0) ? 41'h100_0000_0000
					: {1'b0, prod[i][55:16]};
				sum_s7[i].noise <= mul_s6[i].rneg ? -$signed({1'b0, nm[i][47:16]})
					: $signed({1'b0, nm[i][47:16]});
				sum_s7[i].dneg  <= mul_s6[i].dneg;
				sum_s7[i].acc   <= mul_s6[i].acc;
			end
		end
		if (en[IDX_M1 + 4]) begin
			out_s8.new_force_x <= fsat[0];
			out_s8.new_force_y <= fsat[1];
			out_s8.new_force_z <= fsat[2];
		end
	end

	assign result_valid = vld_q[NSTG-1];
	assign result_data  = out_s8;

endmodule

[hdl/stpf_checker.sv]
// ----------------------------------------------------------------------------
// Slip thermostat pair force checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module stpf_props (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [2:0]        cfg_index,
	input logic [31:0]       cfg_data,
	input logic              pair_valid,
	input logic              pair_stall,
	input stpf_pkg::pair_t   pair_data,
	input logic              result_valid,
	input logic              result_stall,
	input stpf_pkg::result_t result_data
);
	import stpf_pkg::*;

	// A register write starts a recompute, so no pair word is taken right after.
	a_cfg_blocks_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> pair_stall)
		else $error("pair word accepted right after a register write");

	// The derived factors are rebuilt after reset before pairs are taken.
	a_reset_blocks_pairs: assert property (@(posedge clk)
		!arst_n |=> pair_stall)
		else $error("pair word accepted right after reset");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result word changed or dropped");

	a_result_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> !$past(result_stall))
		else $error("result word withdrawn while stalled");

endmodule

bind slip_thermostat_pair_force stpf_props u_stpf_props (.*);

[sim/stpf_checker.sv]
// ----------------------------------------------------------------------------
// Slip thermostat pair force checker
// Watches the register, pair and result channels, predicts each result word
// from its pair word and the current register values, and compares in order.
// ----------------------------------------------------------------------------
module stpf_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              pair_valid,
	input  logic              pair_stall,
	input  stpf_pkg::pair_t   pair_data,
	input  logic              result_valid,
	input  logic              result_stall,
	input  stpf_pkg::result_t result_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import stpf_pkg::*;

	localparam longint unsigned PRODUCT_CAP = 64'h00FF_FFFF_FFFF_FFFF;
	localparam longint unsigned DRAG_CAP    = 64'h0000_0100_0000_0000;

	logic [31:0]        temp_q, fric_q, cutoff_q, tscale_q;
	logic signed [31:0] vref_q [3];
	result_t            force_q [$];

	function automatic longint unsigned magnitude(input longint x);
		return x < 0 ? longint'(0) - x : x;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned v, r, b;
		v = x;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] axis_force(input longint unsigned a, c, t,
			input logic signed [31:0] vel, vref, input logic [15:0] rnd,
			input logic signed [31:0] acc);
		longint vr, slip, diff, rs, noise, total;
		longint unsigned slip_mag, dm, drag, nm;
		vr = vref;
		slip_mag = (magnitude(vr) * t) >> 16;
		slip = vr < 0 ? -longint'(slip_mag) : longint'(slip_mag);
		diff = longint'(vel) - slip;
		dm = magnitude(diff);
		if (dm != 0 && a > PRODUCT_CAP / dm)
			drag = DRAG_CAP;
		else
			drag = (a * dm) >> 16;
		rs = longint'({48'd0, rnd}) - 32768;
		nm = (c * magnitude(rs)) >> 16;
		noise = rs < 0 ? -longint'(nm) : longint'(nm);
		total = longint'(acc) + noise;
		if (diff < 0)
			total = total + longint'(drag);
		else
			total = total - longint'(drag);
		if (total > 64'sd2147483647)
			total = 64'sd2147483647;
		if (total < -64'sd2147483648)
			total = -64'sd2147483648;
		return total[31:0];
	endfunction

	function automatic result_t pair_force(input pair_t p);
		longint unsigned rc, t, w, sw, pdiss, y, x, prand, a, c;
		result_t r;
		rc = cutoff_q;
		t = tscale_q;
		w = 0;
		if (longint'(p.pair_distance) < rc)
			w = ((rc - p.pair_distance) << 16) / rc;
		sw = int_sqrt(w << 16);
		if (t == 0) begin
			pdiss = MAX48;
			y = MAX48;
		end else begin
			x = (longint'(temp_q) * longint'(fric_q)) / t;
			pdiss = (longint'(fric_q) << 16) / t;
			y = (x > MAX48 / 24) ? MAX48 : x * 24;
		end
		prand = int_sqrt(y << 16);
		a = (pdiss * w) >> 16;
		c = (prand * sw) >> 16;
		r.new_force_x = axis_force(a, c, t, p.vel_x, vref_q[0], p.rand_x, p.acc_force_x);
		r.new_force_y = axis_force(a, c, t, p.vel_y, vref_q[1], p.rand_y, p.acc_force_y);
		r.new_force_z = axis_force(a, c, t, p.vel_z, vref_q[2], p.rand_z, p.acc_force_z);
		return r;
	endfunction

	task automatic report(input string field, input logic [31:0] want, got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
	endtask

	assign pending = force_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			temp_q   <= 32'h0001_0000;
			fric_q   <= 32'h0001_0000;
			cutoff_q <= 32'h0001_0000;
			tscale_q <= 32'h0001_0000;
			vref_q   <= '{default: '0};
			force_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TEMPERATURE:   temp_q <= cfg_data;
					CFG_FRICTION:      fric_q <= cfg_data;
					CFG_CUTOFF_RADIUS: cutoff_q <= cfg_data;
					CFG_TIME_SCALE:    tscale_q <= cfg_data;
					CFG_REF_VEL_X:     vref_q[0] <= cfg_data;
					CFG_REF_VEL_Y:     vref_q[1] <= cfg_data;
					CFG_REF_VEL_Z:     vref_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (pair_valid && !pair_stall)
				force_q.push_back(pair_force(pair_data));
			if (result_valid && !result_stall) begin
				if (force_q.size() == 0) begin
					report("unexpected word", '0, result_data.new_force_x);
				end else begin
					want = force_q.pop_front();
					if (want.new_force_x !== result_data.new_force_x)
						report("new_force_x", want.new_force_x, result_data.new_force_x);
					if (want.new_force_y !== result_data.new_force_y)
						report("new_force_y", want.new_force_y, result_data.new_force_y);
					if (want.new_force_z !== result_data.new_force_z)
						report("new_force_z", want.new_force_z, result_data.new_force_z);
				end
			end
		end
	end

endmodule

[sim/tb_slip_thermostat_pair_force.sv]
// ----------------------------------------------------------------------------
// Slip thermostat pair force testbench
// Drives directed and random pair words through several register settings,
// with random gaps and stalls, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module tb_slip_thermostat_pair_force;
	timeunit 1ns;
	timeprecision 1ps;
	import stpf_pkg::*;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int         PHASES = 8;
	localparam int         PAIRS_PER_PHASE = 168;
	localparam int         CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        pair_valid = 1'b0;
	logic        pair_stall;
	pair_t       pair_data = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result_data;
	logic        steady = 1'b0;
	logic [31:0] cutoff_now = 32'h0001_0000;
	int          errors, pending, cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	slip_thermostat_pair_force dut (.*);

	stpf_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		result_stall <= !steady && ($urandom_range(0, 99) < 9);

	function automatic logic signed [31:0] spread_value();
		logic [31:0] m;
		m = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		if (cutoff_now != 0 && $urandom_range(0, 99) < 85)
			p.pair_distance = $urandom_range(0, cutoff_now);
		else
			p.pair_distance = $urandom;
		p.vel_x = spread_value();
		p.vel_y = spread_value();
		p.vel_z = spread_value();
		p.rand_x = $urandom;
		p.rand_y = $urandom;
		p.rand_z = $urandom;
		p.acc_force_x = spread_value();
		p.acc_force_y = spread_value();
		p.acc_force_z = spread_value();
		return p;
	endfunction

	// Holds the word until a clock edge with stall low, then maybe leaves a gap.
	task automatic send_pair(input pair_t p);
		bit taken;
		pair_data <= p;
		pair_valid <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !pair_stall;
			@(posedge clk);
		end
		if (!steady && $urandom_range(0, 99) < 9) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		bit taken;
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_CUTOFF_RADIUS)
			cutoff_now = value;
	endtask

	task automatic write_all(input logic [31:0] temp, fric, cut, ts, vx, vy, vz);
		write_reg(CFG_TEMPERATURE, temp);
		write_reg(CFG_FRICTION, fric);
		write_reg(CFG_CUTOFF_RADIUS, cut);
		write_reg(CFG_TIME_SCALE, ts);
		write_reg(CFG_REF_VEL_X, vx);
		write_reg(CFG_REF_VEL_Y, vy);
		write_reg(CFG_REF_VEL_Z, vz);
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		pair_t p;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset settings: distance edges, field extremes,
		// random fractions at zero, midpoint and top, and saturating forces.
		for (int k = 0; k < 18; k++) begin
			p = random_pair();
			case (k % 6)
				0: p.pair_distance = 0;
				1: p.pair_distance = cutoff_now - 1;
				2: p.pair_distance = cutoff_now;
				3: p.pair_distance = 32'hFFFF_FFFF;
				default: p.pair_distance = $urandom_range(0, cutoff_now);
			endcase
			p.rand_x = (k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'hFFFF : 16'h8000;
			p.rand_y = (k % 3 == 1) ? 16'h0000 : 16'hFFFF;
			p.rand_z = 16'h8000 + k[15:0];
			if (k < 9) begin
				p.vel_x = 32'sh7FFF_FFFF;
				p.vel_y = 32'sh8000_0000;
				p.acc_force_x = 32'sh7FFF_FFFF;
				p.acc_force_y = 32'sh8000_0000;
			end else begin
				p.vel_x = 32'sh8000_0000;
				p.vel_y = 32'sh7FFF_FFFF;
				p.acc_force_x = 32'sh8000_0000;
				p.acc_force_y = 32'sh7FFF_FFFF;
			end
			send_pair(p);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: write_all('1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, $urandom);
					2: begin
						write_all('0, '0, '0, '0, '0, '0, '0);
						write_reg(CFG_UNUSED, $urandom);
					end
					3: write_all($urandom, $urandom, 32'd1, 32'd1, spread_value(),
						spread_value(), spread_value());
					default: write_all($urandom_range(0, 32'h0004_0000),
						$urandom_range(0, 32'h0004_0000),
						$urandom_range(32'h0000_8000, 32'h0004_0000),
						$urandom_range(32'h0000_4000, 32'h0002_0000),
						$signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
						$signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
						$signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
				endcase
			end
			steady = (ph == 4);
			for (int k = 0; k < PAIRS_PER_PHASE; k++)
				send_pair(random_pair());
		end
		steady = 1'b0;
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
